>>> rtl/q2rm_pkg.sv
`default_nettype none
package q2rm_pkg;

   localparam int InWidthDefault  = 16;
   localparam int FracBitsDefault = 14;
   localparam int OutWidth        = 16;
   localparam int NumEntries      = 9;

   typedef struct packed {
      logic signed [InWidthDefault-1:0] quat_w;
      logic signed [InWidthDefault-1:0] quat_x;
      logic signed [InWidthDefault-1:0] quat_y;
      logic signed [InWidthDefault-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] r00;
      logic signed [OutWidth-1:0] r01;
      logic signed [OutWidth-1:0] r02;
      logic signed [OutWidth-1:0] r10;
      logic signed [OutWidth-1:0] r11;
      logic signed [OutWidth-1:0] r12;
      logic signed [OutWidth-1:0] r20;
      logic signed [OutWidth-1:0] r21;
      logic signed [OutWidth-1:0] r22;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/quaternion_to_rotation_matrix.sv
`default_nettype none
// Quaternion to 3x3 rotation matrix.
// req_ channel: one quaternion (w,x,y,z) per transaction, signed integers at any
//   common scale. rsp_ channel: the nine matrix entries, signed fixed point with
//   FRAC_BITS fraction bits, rounded to nearest (ties away from zero).
//   A zero quaternion returns the identity.
// Throughput: one transaction per cycle while the output is empty or taken.
// Pipeline: one multiply stage, one numerator/norm stage, then FRAC_BITS+2
//   stages of the restoring divider, one quotient bit each; the last divider
//   stage is the output register.
// The whole pipeline advances together whenever the output is empty or
//   taken. While a finished transaction waits on rsp_ready, every stage holds
//   and req_ready drops; bubbles inside the pipeline stay where they are.
// Reset clears all valid bits; payload registers are not reset.
module quaternion_to_rotation_matrix #(
   parameter int FRAC_BITS = q2rm_pkg::FracBitsDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  q2rm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output q2rm_pkg::rsp_type  rsp_data
);
   // input width is fixed by the request struct
   localparam int IN_WIDTH = q2rm_pkg::InWidthDefault;
   localparam int MW = 2 * IN_WIDTH + 1;

   logic                 adv;
   logic                 t_valid;
   logic [MW:0]          t_norm;
   logic [9*MW-1:0]      t_mag;
   logic [8:0]           t_neg;

   // single global enable: stall only when output is held
   assign adv       = rsp_ready | ~rsp_valid;
   assign req_ready = adv;

   q2rm_terms #(.IN_WIDTH(IN_WIDTH)) u_terms (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_quat   (req_data),
      .out_valid (t_valid),
      .out_norm  (t_norm),
      .out_mag   (t_mag),
      .out_neg   (t_neg)
   );

   q2rm_divide #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t_valid),
      .in_norm   (t_norm),
      .in_mag    (t_mag),
      .in_neg    (t_neg),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );
endmodule
`default_nettype wire

>>> rtl/q2rm_terms.sv
`default_nettype none
// Products, squared norm and the nine numerators (magnitude/sign), two stages.
module q2rm_terms #(
   parameter int IN_WIDTH = q2rm_pkg::InWidthDefault
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      adv,
   input  wire                      in_valid,
   input  wire [4*IN_WIDTH-1:0]     in_quat,
   output logic                     out_valid,
   output logic [2*IN_WIDTH+1:0]    out_norm,
   output logic [9*(2*IN_WIDTH+1)-1:0] out_mag,
   output logic [8:0]               out_neg
);
   localparam int PW = 2 * IN_WIDTH;
   localparam int MW = PW + 1;
   localparam int NW = PW + 2;

   logic [IN_WIDTH:0] mag_a [4];
   logic              sgn_a [4];
   logic [IN_WIDTH-1:0] c [4];
   logic              big;

   logic [PW-1:0] sq_ff [4];
   logic [PW-1:0] sq_in [4];
   logic [PW-1:0] pr_ff [6];
   logic [PW-1:0] pr_in [6];
   logic [5:0]    prn_ff, prn_in;
   logic          v1_ff;

   // 0:w 1:x 2:y 3:z
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         c[i]     = in_quat[(3-i)*IN_WIDTH +: IN_WIDTH];
         sgn_a[i] = c[i][IN_WIDTH-1];
         mag_a[i] = sgn_a[i] ? ({1'b0, ~c[i]} + 1'b1) : {1'b0, c[i]};
      end
      // norm overflow only when all magnitudes reach 2^(IN_WIDTH-1)
      big = mag_a[0][IN_WIDTH-1] & mag_a[1][IN_WIDTH-1] &
            mag_a[2][IN_WIDTH-1] & mag_a[3][IN_WIDTH-1] & (IN_WIDTH == 32);
      for (int i = 0; i < 4; i++) begin
         if (big) mag_a[i] = mag_a[i] >> 1;
         sq_in[i] = PW'(mag_a[i][IN_WIDTH-1:0] * mag_a[i][IN_WIDTH-1:0]);
      end
      // xy zw yw zx xw yz
      pr_in[0] = PW'(mag_a[1][IN_WIDTH-1:0] * mag_a[2][IN_WIDTH-1:0]);
      pr_in[1] = PW'(mag_a[3][IN_WIDTH-1:0] * mag_a[0][IN_WIDTH-1:0]);
      pr_in[2] = PW'(mag_a[2][IN_WIDTH-1:0] * mag_a[0][IN_WIDTH-1:0]);
      pr_in[3] = PW'(mag_a[3][IN_WIDTH-1:0] * mag_a[1][IN_WIDTH-1:0]);
      pr_in[4] = PW'(mag_a[1][IN_WIDTH-1:0] * mag_a[0][IN_WIDTH-1:0]);
      pr_in[5] = PW'(mag_a[2][IN_WIDTH-1:0] * mag_a[3][IN_WIDTH-1:0]);
      prn_in[0] = sgn_a[1] ^ sgn_a[2];
      prn_in[1] = sgn_a[3] ^ sgn_a[0];
      prn_in[2] = sgn_a[2] ^ sgn_a[0];
      prn_in[3] = sgn_a[3] ^ sgn_a[1];
      prn_in[4] = sgn_a[1] ^ sgn_a[0];
      prn_in[5] = sgn_a[2] ^ sgn_a[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         sq_ff  <= sq_in;
         pr_ff  <= pr_in;
         prn_ff <= prn_in;
      end
   end

   // signed forms, width PW+3
   localparam int SW = PW + 3;
   logic signed [SW-1:0] sq_s [4];
   logic signed [SW-1:0] ps [6];
   logic signed [SW-1:0] e [9];
   logic [NW-1:0] norm_in;
   logic [9*MW-1:0] mag_in;
   logic [8:0] neg_in;

   always_comb begin
      for (int i = 0; i < 4; i++) sq_s[i] = $signed({3'b000, sq_ff[i]});
      for (int i = 0; i < 6; i++)
         ps[i] = prn_ff[i] ? -$signed({3'b000, pr_ff[i]}) : $signed({3'b000, pr_ff[i]});
      e[0] = sq_s[0] + sq_s[1] - sq_s[2] - sq_s[3];
      e[1] = (ps[0] - ps[1]) <<< 1;
      e[2] = (ps[2] + ps[3]) <<< 1;
      e[3] = (ps[0] + ps[1]) <<< 1;
      e[4] = sq_s[0] + sq_s[2] - sq_s[1] - sq_s[3];
      e[5] = (ps[5] - ps[4]) <<< 1;
      e[6] = (ps[3] - ps[2]) <<< 1;
      e[7] = (ps[5] + ps[4]) <<< 1;
      e[8] = sq_s[0] + sq_s[3] - sq_s[1] - sq_s[2];
      norm_in = NW'(sq_ff[0]) + NW'(sq_ff[1]) + NW'(sq_ff[2]) + NW'(sq_ff[3]);
      for (int k = 0; k < 9; k++) begin
         neg_in[k] = e[k][SW-1];
         mag_in[(8-k)*MW +: MW] = neg_in[k] ? MW'(-e[k]) : MW'(e[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= v1_ff;
      end
      if (adv) begin
         out_norm <= norm_in;
         out_mag  <= mag_in;
         out_neg  <= neg_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/q2rm_divide.sv
`default_nettype none
// Pipelined restoring fraction divider: nine lanes, one quotient bit per stage.
module q2rm_divide #(
   parameter int IN_WIDTH  = q2rm_pkg::InWidthDefault,
   parameter int FRAC_BITS = q2rm_pkg::FracBitsDefault
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         adv,
   input  wire                         in_valid,
   input  wire [2*IN_WIDTH+1:0]        in_norm,
   input  wire [9*(2*IN_WIDTH+1)-1:0]  in_mag,
   input  wire [8:0]                   in_neg,
   output logic                        out_valid,
   output q2rm_pkg::rsp_type           out_rsp
);
   localparam int NW = 2 * IN_WIDTH + 2;
   localparam int MW = NW - 1;
   localparam int ST = FRAC_BITS + 2;  // integer bit + FRAC_BITS + round bit
   localparam int QW = FRAC_BITS + 2;
   localparam int OW = q2rm_pkg::OutWidth;

   // element s holds the output of stage s
   logic          v_ff    [ST];
   logic [NW-1:0] n_ff    [ST];
   logic [NW-1:0] r_ff    [ST][9];
   logic [QW-1:0] q_ff    [ST][9];
   logic [8:0]    neg_ff  [ST];

   for (genvar s = 0; s < ST; s++) begin : g_stage
      logic          v_cur;
      logic [NW-1:0] n_cur;
      logic [NW-1:0] r_cur [9];
      logic [QW-1:0] q_cur [9];
      logic [8:0]    neg_cur;
      logic [NW-1:0] r_in [9];
      logic [QW-1:0] q_in [9];

      if (s == 0) begin : g_first
         always_comb begin
            v_cur   = in_valid;
            n_cur   = in_norm;
            neg_cur = in_neg;
            for (int k = 0; k < 9; k++) begin
               r_cur[k] = NW'(in_mag[(8-k)*MW +: MW]);
               q_cur[k] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            v_cur   = v_ff[s-1];
            n_cur   = n_ff[s-1];
            neg_cur = neg_ff[s-1];
            r_cur   = r_ff[s-1];
            q_cur   = q_ff[s-1];
         end
      end

      always_comb begin
         for (int k = 0; k < 9; k++) begin
            if (s == 0) begin
               // integer bit
               if (r_cur[k] >= n_cur) begin
                  r_in[k] = r_cur[k] - n_cur;
                  q_in[k] = {q_cur[k][QW-2:0], 1'b1};
               end else begin
                  r_in[k] = r_cur[k];
                  q_in[k] = {q_cur[k][QW-2:0], 1'b0};
               end
            end else if (r_cur[k] >= n_cur - r_cur[k]) begin
               r_in[k] = r_cur[k] - (n_cur - r_cur[k]);
               q_in[k] = {q_cur[k][QW-2:0], 1'b1};
            end else begin
               r_in[k] = r_cur[k] << 1;
               q_in[k] = {q_cur[k][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_cur;
         end
         if (adv) begin
            n_ff[s]   <= n_cur;
            neg_ff[s] <= neg_cur;
            r_ff[s]   <= r_in;
            q_ff[s]   <= q_in;
         end
      end
   end

   logic [OW-1:0] res [9];
   logic [QW-1:0] rq;
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         rq = (q_ff[ST-1][k] + 1'b1) >> 1;
         res[k] = neg_ff[ST-1][k] ? OW'(-rq) : OW'(rq);
         if (n_ff[ST-1] == '0)
            res[k] = (k == 0 || k == 4 || k == 8) ? OW'(1 << FRAC_BITS) : '0;
      end
      out_valid = v_ff[ST-1];
      out_rsp = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7],
                  res[8]};
   end
endmodule
`default_nettype wire
